// ===== rtl/xdk_pkg.sv =====
// Shared types, constants and tables for the X-drive kinematics block.
package xdk_pkg;

  localparam int NUM_LANES = 4;
  localparam int DIV_STEPS = 32;
  // input capture, products, numerators, divider setup, divider steps, output
  localparam int LATENCY   = 4 + DIV_STEPS + 1;
  localparam int CNT_W     = 5;

  localparam logic [15:0] RADIUS_RST   = 16'd3277;
  localparam logic [15:0] HALF_LEN_RST = 16'd6554;
  localparam logic [15:0] HALF_WID_RST = 16'd6554;
  localparam logic [15:0] ANGLE_RST    = 16'd6434;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam longint unsigned    EPS_Q30     = 64'd1073;

  localparam logic signed [32:0] RES_MAX = 33'sd2147483647;
  localparam logic signed [32:0] RES_MIN = -33'sd2147483648;

  typedef enum logic [3:0] {
    CFG_RADIUS   = 4'd0,
    CFG_HALF_LEN = 4'd1,
    CFG_HALF_WID = 4'd2,
    CFG_ANGLE    = 4'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_DEGEN = 2'd1,
    STATUS_SAT   = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [32:0] arm;
    logic [15:0]        radius;
    logic               degen;
    logic               rzero;
  } geom_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] den;
    logic [31:0] quo;
    logic        neg;
    logic        ovf;
  } div_lane_t;

  function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/xdk_geom.sv =====
// Geometry registers and the sequencer that derives cosine, sine and lever arm.
module xdk_geom #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_addr_i,
  input  logic [15:0]   cfg_data_i,
  output xdk_pkg::geom_t geom_o,
  output logic          busy_o
);
  import xdk_pkg::*;

  localparam longint unsigned TolShift = 64'd1 << (31 - TRIG_ITERATIONS);
  localparam logic [32:0] Tol = (TolShift < EPS_Q30) ? 33'(EPS_Q30) : 33'(TolShift);
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(TRIG_ITERATIONS - 1);

  typedef enum logic [6:0] {
    G_ANGLE = 7'b0000001,
    G_ROT   = 7'b0000010,
    G_FLIP  = 7'b0000100,
    G_PROD  = 7'b0001000,
    G_ARM   = 7'b0010000,
    G_CHK   = 7'b0100000,
    G_DONE  = 7'b1000000
  } geom_state_e;

  geom_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [15:0] radius_q, half_len_q, half_wid_q, angle_q;

  logic signed [35:0] ang_q;
  logic signed [33:0] x_q, y_q;
  logic               flip_q;
  logic signed [31:0] c_q, s_q;
  logic signed [48:0] prod_l_q, prod_w_q;
  logic signed [32:0] arm_q;
  logic               degen_q, rzero_q;

  logic signed [35:0] ang_ext, atan_ext;
  logic signed [33:0] dx, dy;
  logic [31:0] c_abs, s_abs;
  logic [32:0] arm_abs;

  assign ang_ext  = {{3{angle_q[15]}}, angle_q, 17'd0};
  assign atan_ext = $signed(36'(atan_q30(cnt_q)));
  assign dx       = y_q >>> cnt_q;
  assign dy       = x_q >>> cnt_q;
  assign c_abs    = c_q[31] ? 32'(-c_q) : 32'(c_q);
  assign s_abs    = s_q[31] ? 32'(-s_q) : 32'(s_q);
  assign arm_abs  = arm_q[32] ? 33'(-arm_q) : 33'(arm_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      G_ANGLE: state_d = G_ROT;
      G_ROT:   if (cnt_q == CntLast) state_d = G_FLIP;
      G_FLIP:  state_d = G_PROD;
      G_PROD:  state_d = G_ARM;
      G_ARM:   state_d = G_CHK;
      G_CHK:   state_d = G_DONE;
      G_DONE:  state_d = G_DONE;
      default: state_d = G_ANGLE;
    endcase
    // any register write restarts the derivation
    if (cfg_we_i) state_d = G_ANGLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= G_ANGLE;
      cnt_q      <= '0;
      radius_q   <= RADIUS_RST;
      half_len_q <= HALF_LEN_RST;
      half_wid_q <= HALF_WID_RST;
      angle_q    <= ANGLE_RST;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_q == G_ROT) ? cnt_q + 1'b1 : '0;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_RADIUS:   radius_q   <= cfg_data_i;
          CFG_HALF_LEN: half_len_q <= cfg_data_i;
          CFG_HALF_WID: half_wid_q <= cfg_data_i;
          CFG_ANGLE:    angle_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      G_ANGLE: begin
        // fold the angle into plus or minus half pi and remember the sign flip
        if (ang_ext > HALF_PI_Q30) begin
          ang_q  <= ang_ext - PI_Q30;
          flip_q <= 1'b1;
        end else if (ang_ext < -HALF_PI_Q30) begin
          ang_q  <= ang_ext + PI_Q30;
          flip_q <= 1'b1;
        end else begin
          ang_q  <= ang_ext;
          flip_q <= 1'b0;
        end
        x_q <= GAIN_Q30;
        y_q <= '0;
      end
      G_ROT: begin
        if (!ang_q[35]) begin
          x_q   <= x_q - dx;
          y_q   <= y_q + dy;
          ang_q <= ang_q - atan_ext;
        end else begin
          x_q   <= x_q + dx;
          y_q   <= y_q - dy;
          ang_q <= ang_q + atan_ext;
        end
      end
      G_FLIP: begin
        c_q <= flip_q ? 32'(-x_q) : 32'(x_q);
        s_q <= flip_q ? 32'(-y_q) : 32'(y_q);
      end
      G_PROD: begin
        prod_l_q <= 49'($signed({1'b0, half_len_q})) * 49'(s_q);
        prod_w_q <= 49'($signed({1'b0, half_wid_q})) * 49'(c_q);
      end
      G_ARM: arm_q <= 33'((prod_l_q + prod_w_q + 49'sd32768) >>> 16);
      G_CHK: begin
        degen_q <= (33'(c_abs) <= Tol) || (33'(s_abs) <= Tol) || (arm_abs <= Tol);
        rzero_q <= (radius_q == '0);
      end
      default: ;
    endcase
  end

  assign busy_o        = (state_q != G_DONE);
  assign geom_o.c      = c_q;
  assign geom_o.s      = s_q;
  assign geom_o.arm    = arm_q;
  assign geom_o.radius = radius_q;
  assign geom_o.degen  = degen_q;
  assign geom_o.rzero  = rzero_q;

endmodule

// ===== rtl/xdk_front.sv =====
// Front pipeline: request capture, products, numerators and divider setup.
module xdk_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic                inv_i,
  input  logic [3:0][31:0]    value_i,
  input  xdk_pkg::geom_t      geom_i,
  output logic                vld_o,
  output logic                degen_o,
  output xdk_pkg::div_lane_t [xdk_pkg::NUM_LANES-1:0] lane_o
);
  import xdk_pkg::*;

  // stage 1: capture
  logic vld1_q, inv1_q;
  logic [3:0][31:0] v1_q;
  // stage 2: products or sums
  logic vld2_q, inv2_q;
  logic signed [64:0] p_q [3];
  logic signed [64:0] p_d [3];
  // stage 3: numerators and divisors
  logic vld3_q, zero3_q;
  logic signed [63:0] n_q [NUM_LANES];
  logic signed [32:0] d_q [NUM_LANES];
  logic signed [63:0] n_d [NUM_LANES];
  logic signed [32:0] d_d [NUM_LANES];
  logic zero_d;
  // stage 4: divider setup
  logic vld4_q, degen4_q;
  div_lane_t [NUM_LANES-1:0] lane_q, lane_d;

  logic signed [31:0] va, vb, vc, vd;
  logic signed [33:0] sum0, sum1, sum2;
  logic signed [64:0] tx, ty, tw;
  logic signed [50:0] m [3];

  assign va = $signed(v1_q[0]);
  assign vb = $signed(v1_q[1]);
  assign vc = $signed(v1_q[2]);
  assign vd = $signed(v1_q[3]);

  always_comb begin
    sum0   = 34'(va) + 34'(vb) + 34'(vc) + 34'(vd);
    sum1   = 34'(vb) + 34'(vc) - 34'(va) - 34'(vd);
    sum2   = 34'(vb) + 34'(vd) - 34'(va) - 34'(vc);
    p_d[0] = inv1_q ? 65'(sum0) : 65'(64'(geom_i.c) * 64'(va));
    p_d[1] = inv1_q ? 65'(sum1) : 65'(64'(geom_i.s) * 64'(vb));
    p_d[2] = inv1_q ? 65'(sum2) : 65'(geom_i.arm) * 65'(vc);
  end

  always_comb begin
    tx = (p_q[0] + 65'sd8192) >>> 14;
    ty = (p_q[1] + 65'sd8192) >>> 14;
    tw = (p_q[2] + 65'sd8192) >>> 14;
    for (int k = 0; k < 3; k++) begin
      m[k] = 51'($signed(p_q[k][33:0])) * 51'($signed({1'b0, geom_i.radius}));
    end
    zero_d = geom_i.rzero || (inv2_q && geom_i.degen);
    if (inv2_q) begin
      n_d[0] = 64'(m[0]) <<< 12;
      n_d[1] = 64'(m[1]) <<< 12;
      n_d[2] = 64'(m[2]) <<< 12;
      n_d[3] = '0;
      d_d[0] = 33'(geom_i.c);
      d_d[1] = 33'(geom_i.s);
      d_d[2] = geom_i.arm;
      d_d[3] = 33'sd1;
    end else begin
      n_d[0] = 64'(tx - ty - tw);
      n_d[1] = 64'(tx + ty + tw);
      n_d[2] = 64'(tx + ty - tw);
      n_d[3] = 64'(tx - ty + tw);
      for (int k = 0; k < NUM_LANES; k++) begin
        d_d[k] = $signed({17'd0, geom_i.radius});
      end
    end
    // zero radius, or flat geometry on an inverse request: every lane yields zero
    if (zero_d) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        n_d[k] = '0;
        d_d[k] = 33'sd1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_d[k].neg = n_q[k][63] ^ d_q[k][32];
      lane_d[k].den = d_q[k][32] ? 32'(-d_q[k]) : 32'(d_q[k]);
      lane_d[k].rem = (n_q[k][63] ? 64'(-n_q[k]) : 64'(n_q[k]))
                      + 64'(lane_d[k].den >> 1);
      lane_d[k].ovf = (lane_d[k].rem >= {lane_d[k].den, 32'd0});
      lane_d[k].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    inv1_q   <= inv_i;
    v1_q     <= value_i;
    inv2_q   <= inv1_q;
    p_q      <= p_d;
    zero3_q  <= zero_d;
    n_q      <= n_d;
    d_q      <= d_d;
    degen4_q <= zero3_q;
    lane_q   <= lane_d;
  end

  assign vld_o   = vld4_q;
  assign degen_o = degen4_q;
  assign lane_o  = lane_q;

endmodule

// ===== rtl/xdk_div.sv =====
// Pipelined restoring divider, one quotient bit per stage for all four lanes.
module xdk_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic                degen_i,
  input  xdk_pkg::div_lane_t [xdk_pkg::NUM_LANES-1:0] lane_i,
  output logic                vld_o,
  output logic                degen_o,
  output xdk_pkg::div_lane_t [xdk_pkg::NUM_LANES-1:0] lane_o
);
  import xdk_pkg::*;

  logic [DIV_STEPS-1:0] vld_q, degen_q;
  div_lane_t [NUM_LANES-1:0] st_q [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    localparam int Bit = DIV_STEPS - 1 - g;
    div_lane_t [NUM_LANES-1:0] cur, nxt;
    logic [63:0] sub [NUM_LANES];

    if (g == 0) begin : g_first
      assign cur = lane_i;
    end else begin : g_rest
      assign cur = st_q[g-1];
    end

    always_comb begin
      nxt = cur;
      for (int k = 0; k < NUM_LANES; k++) begin
        sub[k] = 64'(cur[k].den) << Bit;
        if (cur[k].rem >= sub[k]) begin
          nxt[k].rem      = cur[k].rem - sub[k];
          nxt[k].quo[Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[g] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STEPS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    degen_q <= {degen_q[DIV_STEPS-2:0], degen_i};
  end

  assign vld_o   = vld_q[DIV_STEPS-1];
  assign degen_o = degen_q[DIV_STEPS-1];
  assign lane_o  = st_q[DIV_STEPS-1];

endmodule

// ===== rtl/x_drive_wheel_body_kinematics.sv =====
// Top level of the X-drive forward and inverse kinematics pipeline.
// A request is taken on start_i while busy_o is low, one per cycle with no gaps,
// and its result appears on done_o after four front stages (capture, multiply,
// combine, divider setup), a 32-stage restoring divider that resolves one
// quotient bit per stage, and the output register. The receiver cannot stall.
// busy_o is high after reset and after every register write while the geometry
// sequencer derives cosine, sine and lever arm, with the CORDIC taking one
// iteration a cycle. Registers are taken on every cycle (cfg_ready_o stays
// high) and may be written only when no request is in flight.
module x_drive_wheel_body_kinematics #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [31:0] value_a_i,
  input  logic [31:0] value_b_i,
  input  logic [31:0] value_c_i,
  input  logic [31:0] value_d_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] result_a_o,
  output logic [31:0] result_b_o,
  output logic [31:0] result_c_o,
  output logic [31:0] result_d_o,
  output logic [1:0]  status_o
);
  import xdk_pkg::*;

  geom_t geom;
  logic  geom_busy, cfg_we, accept;
  logic  f_vld, f_degen, d_vld, d_degen;
  div_lane_t [NUM_LANES-1:0] f_lane, d_lane;

  logic [NUM_LANES-1:0][31:0] res_d, res_q;
  logic [NUM_LANES-1:0] sat;
  logic signed [32:0] val [NUM_LANES];
  status_e status_d, status_q;
  logic done_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = start_i && !busy_o;
  assign busy_o      = geom_busy;

  xdk_geom #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_addr_i(cfg_addr_i),
    .cfg_data_i(cfg_data_i),
    .geom_o    (geom),
    .busy_o    (geom_busy)
  );

  xdk_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (accept),
    .inv_i  (req_type_i),
    .value_i({value_d_i, value_c_i, value_b_i, value_a_i}),
    .geom_i (geom),
    .vld_o  (f_vld),
    .degen_o(f_degen),
    .lane_o (f_lane)
  );

  xdk_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (f_vld),
    .degen_i(f_degen),
    .lane_i (f_lane),
    .vld_o  (d_vld),
    .degen_o(d_degen),
    .lane_o (d_lane)
  );

  // apply sign, then clamp to the signed 32-bit range
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      val[k]   = d_lane[k].neg ? -$signed({1'b0, d_lane[k].quo})
                               : $signed({1'b0, d_lane[k].quo});
      sat[k]   = d_lane[k].ovf || (val[k] > RES_MAX) || (val[k] < RES_MIN);
      res_d[k] = sat[k] ? (d_lane[k].neg ? RES_MIN[31:0] : RES_MAX[31:0]) : val[k][31:0];
    end
    if (d_degen)     status_d = STATUS_DEGEN;
    else if (|sat)   status_d = STATUS_SAT;
    else             status_d = STATUS_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    status_q <= status_d;
  end

  assign done_o     = done_q;
  assign result_a_o = res_q[0];
  assign result_b_o = res_q[1];
  assign result_c_o = res_q[2];
  assign result_d_o = res_q[3];
  assign status_o   = status_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("request did not complete at the pipeline latency");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> busy_o)
    else $error("register write did not restart geometry derivation");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_DEGEN) |->
      (result_a_o == '0 && result_b_o == '0 && result_c_o == '0 && result_d_o == '0))
    else $error("degenerate request produced nonzero results");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_SAT) |->
      (result_a_o == 32'h7fffffff || result_a_o == 32'h80000000 ||
       result_b_o == 32'h7fffffff || result_b_o == 32'h80000000 ||
       result_c_o == 32'h7fffffff || result_c_o == 32'h80000000 ||
       result_d_o == 32'h7fffffff || result_d_o == 32'h80000000))
    else $error("saturation status without a clamped result");

endmodule

// ===== tb/xdk_checker.sv =====
// Scoreboard for the X-drive kinematics block: tracks registers, predicts and compares results.
`timescale 1ns / 1ps

module xdk_checker
  import xdk_pkg::*;
#(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        req_type_i,
  input  logic [31:0] value_a_i,
  input  logic [31:0] value_b_i,
  input  logic [31:0] value_c_i,
  input  logic [31:0] value_d_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  input  logic        done_i,
  input  logic [31:0] result_a_i,
  input  logic [31:0] result_b_i,
  input  logic [31:0] result_c_i,
  input  logic [31:0] result_d_i,
  input  logic [1:0]  status_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o,
  output int          degen_seen_o,
  output int          sat_seen_o
);

  typedef struct {
    logic [31:0] rate_a;
    logic [31:0] rate_b;
    logic [31:0] rate_c;
    logic [31:0] rate_d;
    status_e     status;
  } motion_t;

  localparam longint unsigned ATAN_TBL [31] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1
  };

  logic [15:0] radius_q, half_len_q, half_wid_q, angle_q;
  motion_t     motion_q[$];

  function automatic void roller_trig(input logic [15:0] ang, output longint cs,
                                      output longint sn);
    longint a, x, y, dx, dy;
    bit     flip;
    a    = longint'($signed(ang)) * 131072;
    x    = longint'(GAIN_Q30);
    y    = 0;
    flip = 0;
    if (a > longint'(HALF_PI_Q30)) begin
      a -= longint'(PI_Q30);
      flip = 1;
    end else if (a < -longint'(HALF_PI_Q30)) begin
      a += longint'(PI_Q30);
      flip = 1;
    end
    for (int i = 0; i < TRIG_ITERATIONS && i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= longint'(ATAN_TBL[i]);
      end else begin
        x += dx; y -= dy; a += longint'(ATAN_TBL[i]);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint rounded_quotient(input longint n, input longint d);
    longint unsigned un, ud, q;
    un = (n < 0) ? longint'(-n) : n;
    ud = (d < 0) ? longint'(-d) : d;
    if (ud == 0) return 0;
    q = (un + ud / 2) / ud;
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp32(input longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic motion_t predict_motion(input logic inverse, input logic [31:0] a_in,
                                            input logic [31:0] b_in, input logic [31:0] c_in,
                                            input logic [31:0] d_in);
    motion_t m;
    longint  cs, sn, arm, r, va, vb, vc, vd, tx, ty, tw, scale, tol;
    longint  res[4];
    bit      ovf;
    bit      degen;
    roller_trig(angle_q, cs, sn);
    r   = longint'(radius_q);
    va  = longint'($signed(a_in));
    vb  = longint'($signed(b_in));
    vc  = longint'($signed(c_in));
    vd  = longint'($signed(d_in));
    tol = longint'(1) << (31 - TRIG_ITERATIONS);
    if (tol < longint'(EPS_Q30)) tol = longint'(EPS_Q30);
    arm = (longint'(half_len_q) * sn + longint'(half_wid_q) * cs + 32768) >>> 16;
    res   = '{0, 0, 0, 0};
    ovf   = 0;
    degen = 0;
    if (r == 0) begin
      degen = 1;
    end else if (!inverse) begin
      tx = (cs * va + 8192) >>> 14;
      ty = (sn * vb + 8192) >>> 14;
      tw = (arm * vc + 8192) >>> 14;
      res[0] = rounded_quotient(tx - ty - tw, r);
      res[1] = rounded_quotient(tx + ty + tw, r);
      res[2] = rounded_quotient(tx + ty - tw, r);
      res[3] = rounded_quotient(tx - ty + tw, r);
    end else if ((cs < 0 ? -cs : cs) <= tol || (sn < 0 ? -sn : sn) <= tol ||
                 (arm < 0 ? -arm : arm) <= tol) begin
      degen = 1;
    end else begin
      scale  = r * 4096;
      res[0] = rounded_quotient((va + vb + vc + vd) * scale, cs);
      res[1] = rounded_quotient((vb + vc - va - vd) * scale, sn);
      res[2] = rounded_quotient((vb + vd - va - vc) * scale, arm);
    end
    m.rate_a = clamp32(res[0], ovf);
    m.rate_b = clamp32(res[1], ovf);
    m.rate_c = clamp32(res[2], ovf);
    m.rate_d = clamp32(res[3], ovf);
    m.status = degen ? STATUS_DEGEN : (ovf ? STATUS_SAT : STATUS_OK);
    return m;
  endfunction

  assign pending_o = motion_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    motion_t want;
    int      nerr;
    nerr = 0;
    if (!rst_ni) begin
      radius_q     <= RADIUS_RST;
      half_len_q   <= HALF_LEN_RST;
      half_wid_q   <= HALF_WID_RST;
      angle_q      <= ANGLE_RST;
      errors_o     <= 0;
      checked_o    <= 0;
      degen_seen_o <= 0;
      sat_seen_o   <= 0;
      motion_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_RADIUS:   radius_q   <= cfg_data_i;
          CFG_HALF_LEN: half_len_q <= cfg_data_i;
          CFG_HALF_WID: half_wid_q <= cfg_data_i;
          CFG_ANGLE:    angle_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        motion_q.push_back(predict_motion(req_type_i, value_a_i, value_b_i,
                                          value_c_i, value_d_i));
      if (done_i) begin
        if (motion_q.size() == 0) begin
          $error("result with no request outstanding");
          nerr++;
        end else begin
          want = motion_q.pop_front();
          checked_o <= checked_o + 1;
          if (want.status == STATUS_DEGEN) degen_seen_o <= degen_seen_o + 1;
          if (want.status == STATUS_SAT) sat_seen_o <= sat_seen_o + 1;
          if (result_a_i !== want.rate_a) begin
            $error("result_a expected %h got %h", want.rate_a, result_a_i);
            nerr++;
          end
          if (result_b_i !== want.rate_b) begin
            $error("result_b expected %h got %h", want.rate_b, result_b_i);
            nerr++;
          end
          if (result_c_i !== want.rate_c) begin
            $error("result_c expected %h got %h", want.rate_c, result_c_i);
            nerr++;
          end
          if (result_d_i !== want.rate_d) begin
            $error("result_d expected %h got %h", want.rate_d, result_d_i);
            nerr++;
          end
          if (status_i !== want.status) begin
            $error("status expected %0d got %0d", want.status, status_i);
            nerr++;
          end
        end
      end
      errors_o <= errors_o + nerr;
    end
  end

endmodule

// ===== tb/x_drive_wheel_body_kinematics_tb.sv =====
// Stimulus and verdict for the X-drive kinematics block across several geometry settings.
`timescale 1ns / 1ps

module x_drive_wheel_body_kinematics_tb;
  import xdk_pkg::*;

  localparam int NUM_PHASES = 11;
  localparam int PHASE_ITEMS = 140;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        req_type_i = 0;
  logic [31:0] value_a_i = '0, value_b_i = '0, value_c_i = '0, value_d_i = '0;
  logic        cfg_valid_i = 0;
  logic [3:0]  cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        busy_o, cfg_ready_o, done_o;
  logic [31:0] result_a_o, result_b_o, result_c_o, result_d_o;
  logic [1:0]  status_o;
  int          errors, pending, checked, degen_seen, sat_seen;
  bit          idle_gaps;

  x_drive_wheel_body_kinematics dut (.*);

  xdk_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_type_i,
    .value_a_i, .value_b_i, .value_c_i, .value_d_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_addr_i, .cfg_data_i,
    .done_i(done_o), .result_a_i(result_a_o), .result_b_i(result_b_o),
    .result_c_i(result_c_o), .result_d_i(result_d_o), .status_i(status_o),
    .errors_o(errors), .pending_o(pending), .checked_o(checked),
    .degen_seen_o(degen_seen), .sat_seen_o(sat_seen)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      2: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27));
    endcase
  endfunction

  task automatic send_request(input logic inv, input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d);
    req_type_i <= inv;
    value_a_i  <= a;
    value_b_i  <= b;
    value_c_i  <= c;
    value_d_i  <= d;
    start_i    <= 1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_valid_i <= 1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [15:0] r, input logic [15:0] hl,
                              input logic [15:0] hw, input logic [15:0] ang);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_HALF_LEN, hl);
    write_reg(CFG_HALF_WID, hw);
    write_reg(CFG_ANGLE, ang);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] geo [NUM_PHASES][4];
    geo[0]  = '{RADIUS_RST, HALF_LEN_RST, HALF_WID_RST, ANGLE_RST};
    geo[1]  = '{16'd1, 16'hffff, 16'hffff, 16'sd25736};
    geo[2]  = '{16'hffff, 16'd0, 16'd0, -16'sd25736};
    geo[3]  = '{16'd0, 16'd6554, 16'd6554, 16'sd6434};
    geo[4]  = '{16'd3277, 16'd6554, 16'd9830, 16'd0};
    geo[5]  = '{16'd2000, 16'd4000, 16'd3000, 16'sd12868};
    geo[6]  = '{16'd500, 16'd30000, 16'd100, 16'h8000};
    geo[7]  = '{16'd40000, 16'd100, 16'd50000, 16'h7fff};
    geo[8]  = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    geo[9]  = '{16'($urandom_range(1, 8000)), 16'($urandom), 16'($urandom),
                16'($urandom)};
    geo[10] = '{16'd3277, 16'd6554, 16'd6554, 16'sd6434};
    idle_gaps = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset geometry: extremes of every field, both directions
    send_request(0, '0, '0, '0, '0);
    send_request(1, '0, '0, '0, '0);
    send_request(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_request(1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_request(0, 32'h0001_0000, '0, '0, 32'hffff_ffff);
    send_request(0, '0, 32'h0001_0000, '0, '0);
    send_request(0, '0, '0, 32'h0001_0000, '0);
    send_request(1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_request(1, 32'hffff_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
    send_request(1, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send_request(0, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_geometry(geo[p][0], geo[p][1], geo[p][2], geo[p][3]);
      idle_gaps = (p != NUM_PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // stretches without gaps inside each phase
        if (i == PHASE_ITEMS / 2) idle_gaps = 0;
        send_request($urandom_range(0, 1), pick_value(), pick_value(),
                     pick_value(), pick_value());
      end
    end
    drain();
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("checked %0d results over %0d geometry settings", checked, NUM_PHASES + 1);
    $display("degenerate results %0d, saturated results %0d", degen_seen, sat_seen);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
